// File: rtl/core/kprt_pkg.sv
// Package for the key press recency table: opcodes, status codes, command and status structs.
// No dependencies.
`default_nettype none
package kprt_pkg;

  localparam int KeyW = 8;
  localparam int FrameW = 8;
  localparam int CountW = 16;
  localparam int PosW = 7;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_CLEAN  = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_CLEANED  = 3'd3,
    ST_READ_OK  = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request, point cursor at head
    logic rd_cursor;  // read memory at cursor
    logic step;       // act on the entry just read and advance
    logic scan_free;  // check one slot in the free search
    logic insert;     // write new entry at free slot
    logic finish;     // build result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    opcode_t op;
    logic    cursor_end;  // cursor is the end marker or walk limit hit
    logic    hit;         // current entry matches / position reached
    logic    free_found;
    logic    free_done;   // free search exhausted
  } stat_t;

endpackage
`default_nettype wire

// File: rtl/core/key_press_recency_table.sv
// Top level of the key press recency table: streaming ports around controller and datapath.
// Depends on kprt_pkg, kprt_controller, kprt_datapath.
//
// Usage: one request enters on the s_axis group and one result leaves on m_axis.
// Request tdata holds opcode, key_row, key_column, frame_tag, position.
// Update looks up the key by walking the recency list, then if absent searches
// for the highest free slot and links the new key in at the head.
// Clean walks the whole list, unlinking entries of another frame and bumping
// the hold counter of the rest (saturating). Read walks to the given position.
// A walk passes three states per list entry walked (fetch, memory read, examine);
// an insert adds the free search, one slot at a time, before the result is built.
// One request at a time: s_tready stays low until the result has been taken.
// When the receiver stalls, the result holds in its register.
// Reset (rst, synchronous) empties the table at once; no clearing pass.
`default_nettype none
module key_press_recency_table
  import kprt_pkg::*;
#(
  parameter int SLOTS = 96
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // opcode[1:0], key_row[5:2], key_column[9:6], frame_tag[17:10], position[24:18]
  input  wire logic [31:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[2:0], out_row[6:3], out_column[10:7], hold_count[26:11],
  // removed_count[34:27], entry_count[42:35]
  output logic [47:0]      m_axis_tdata
);

  cmd_t  cmd;
  stat_t stat;
  logic  inserted;
  logic [2:0]        res_status;
  logic [KeyW-1:0]   res_key;
  logic [CountW-1:0] res_hold;
  logic [7:0]        res_removed;
  logic [7:0]        res_count;
  logic [2:0]        status_fix;

  kprt_controller u_ctrl (
    .clk(clk), .rst(rst),
    .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
    .cmd(cmd), .stat(stat), .inserted(inserted)
  );

  kprt_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_op(s_axis_tdata[1:0]),
    .in_key({s_axis_tdata[5:2], s_axis_tdata[9:6]}),
    .in_frame(s_axis_tdata[17:10]),
    .in_pos(s_axis_tdata[24:18]),
    .res_status(res_status), .res_key(res_key), .res_hold(res_hold),
    .res_removed(res_removed), .res_count(res_count)
  );

  // separate a fresh insertion from an update of a present key
  assign status_fix = (res_status == ST_UPDATED && inserted) ? ST_INSERTED : res_status;

  assign m_axis_tdata = {5'd0, res_count, res_removed, res_hold,
                         res_key[3:0], res_key[7:4], status_fix};

endmodule
`default_nettype wire

// File: rtl/core/kprt_datapath.sv
// Datapath of the key press recency table: slot memory, list pointers, cursor and result.
// Depends on kprt_pkg.
`default_nettype none
module kprt_datapath
  import kprt_pkg::*;
#(
  parameter int SLOTS = 96
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output stat_t                  stat,
  input  wire logic [1:0]        in_op,
  input  wire logic [KeyW-1:0]   in_key,
  input  wire logic [FrameW-1:0] in_frame,
  input  wire logic [PosW-1:0]   in_pos,
  output logic [2:0]             res_status,
  output logic [KeyW-1:0]        res_key,
  output logic [CountW-1:0]      res_hold,
  output logic [7:0]             res_removed,
  output logic [7:0]             res_count
);

  localparam logic [PosW-1:0] EndMark = '1;

  // one word per slot: key, frame, counter, link
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [FrameW-1:0] frame;
    logic [CountW-1:0] counter;
    logic [PosW-1:0]   link;
  } slot_t;

  slot_t mem [SLOTS];
  slot_t rd_word;
  slot_t prev_word;
  logic [SLOTS-1:0] used;

  logic [PosW-1:0]   head;
  logic [PosW-1:0]   length;
  opcode_t           op;
  logic [KeyW-1:0]   key;
  logic [FrameW-1:0] frame;
  logic [PosW-1:0]   pos;
  logic [PosW-1:0]   cursor;
  logic [PosW-1:0]   prev;
  logic [PosW-1:0]   nsteps;
  logic [PosW-1:0]   free_idx;
  logic              found;
  logic [7:0]        removed;

  logic              wr_en;
  logic [PosW-1:0]   wr_addr;
  slot_t             wr_data;

  logic cursor_valid;
  assign cursor_valid = (cursor < PosW'(SLOTS)) && (nsteps < PosW'(SLOTS));

  always_comb begin
    stat.op = op;
    stat.cursor_end = !cursor_valid;
    unique case (op)
      OP_UPDATE: stat.hit = rd_word.key == key;
      OP_READ:   stat.hit = nsteps == pos;
      default:   stat.hit = 1'b0;
    endcase
    stat.free_found = !used[free_idx];
    stat.free_done = free_idx == '0;
  end

  // single memory write: the entry at the cursor, a link fix on the
  // previous kept entry, or a fresh insert
  always_comb begin
    wr_en = 1'b0;
    wr_addr = cursor;
    wr_data = rd_word;
    if (cmd.step && cursor_valid) begin
      if (op == OP_UPDATE && stat.hit) begin
        wr_en = 1'b1;
        wr_data.frame = frame;
      end else if (op == OP_CLEAN) begin
        if (rd_word.frame == frame) begin
          wr_en = 1'b1;
          if (rd_word.counter != CountMax) wr_data.counter = rd_word.counter + 1'b1;
        end else if (prev != EndMark) begin
          // prev was stepped through earlier, rewrite it from its held copy
          wr_en = 1'b1;
          wr_addr = prev;
          wr_data = prev_word;
          wr_data.link = rd_word.link;
        end
      end
    end else if (cmd.insert) begin
      wr_en = 1'b1;
      wr_addr = free_idx;
      wr_data = '{key: key, frame: frame, counter: '0, link: head};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_cursor) rd_word <= mem[cursor];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      head <= EndMark;
      length <= '0;
    end else begin
      if (cmd.load) begin
        op <= opcode_t'(in_op);
        key <= in_key;
        frame <= in_frame;
        pos <= in_pos;
        cursor <= head;
        prev <= EndMark;
        nsteps <= '0;
        free_idx <= PosW'(SLOTS - 1);
        found <= 1'b0;
        removed <= '0;
      end
      if (cmd.step && cursor_valid) begin
        nsteps <= nsteps + 1'b1;
        cursor <= rd_word.link;
        if (op == OP_UPDATE && stat.hit) found <= 1'b1;
        if (op == OP_CLEAN) begin
          if (rd_word.frame == frame) begin
            prev <= cursor;
            prev_word <= wr_data;
          end else begin
            used[cursor] <= 1'b0;
            removed <= removed + 1'b1;
            length <= length - 1'b1;
            if (prev == EndMark) head <= rd_word.link;
            else prev_word.link <= rd_word.link;
          end
        end
      end
      if (cmd.scan_free && used[free_idx] && free_idx != '0) free_idx <= free_idx - 1'b1;
      if (cmd.insert) begin
        used[free_idx] <= 1'b1;
        head <= free_idx;
        length <= length + 1'b1;
        found <= 1'b1;
      end
      if (cmd.finish) begin
        res_key <= '0;
        res_hold <= '0;
        res_removed <= '0;
        unique case (op)
          OP_UPDATE: res_status <= found ? ST_UPDATED : ST_DROPPED;
          OP_CLEAN: begin
            res_status <= ST_CLEANED;
            res_removed <= removed;
          end
          OP_READ: begin
            // the walk stopped on the requested position
            if (cursor_valid && stat.hit) begin
              res_status <= ST_READ_OK;
              res_key <= rd_word.key;
              res_hold <= rd_word.counter;
            end else begin
              res_status <= ST_EMPTY;
            end
          end
          default: res_status <= ST_EMPTY;
        endcase
        res_count <= {1'b0, length};
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/kprt_controller.sv
// Controller of the key press recency table: sequences list walks and the free slot search.
// Depends on kprt_pkg.
`default_nettype none
module kprt_controller
  import kprt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_valid,
  output logic       s_ready,
  output logic       m_valid,
  input  wire logic  m_ready,
  output cmd_t       cmd,
  input  wire stat_t stat,
  output logic       inserted
);

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_WAIT, S_EXAM, S_FREE, S_DONE, S_OUT
  } state_t;

  state_t state;

  assign s_ready = (state == S_IDLE) && !m_valid;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.load = s_valid && s_ready;
      S_FETCH: cmd.rd_cursor = 1'b1;
      S_EXAM:  cmd.step = !stat.cursor_end && !(stat.op == OP_READ && stat.hit);
      S_FREE:  begin
        cmd.scan_free = 1'b1;
        cmd.insert = stat.free_found;
      end
      S_DONE:  cmd.finish = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_valid <= 1'b0;
      inserted <= 1'b0;
    end else begin
      if (m_valid && m_ready) m_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_valid && s_ready) begin
          inserted <= 1'b0;
          state <= S_FETCH;
        end
        S_FETCH: state <= S_WAIT;
        S_WAIT:  state <= S_EXAM;
        S_EXAM: begin
          if (stat.cursor_end) begin
            state <= (stat.op == OP_UPDATE) ? S_FREE : S_DONE;
          end else if (stat.op == OP_UPDATE && stat.hit) begin
            state <= S_DONE;
          end else if (stat.op == OP_READ && stat.hit) begin
            state <= S_DONE;
          end else if (stat.op == OP_NONE) begin
            state <= S_DONE;
          end else begin
            state <= S_FETCH;
          end
        end
        S_FREE: begin
          if (stat.free_found) begin
            inserted <= 1'b1;
            state <= S_DONE;
          end else if (stat.free_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: state <= S_OUT;
        S_OUT: begin
          m_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
